[design/spd_pkg.sv]
// Shared types and constants for the spectral peak command detector.
package spd_pkg;

	localparam int SPECTRUM_BINS = 1024;
	localparam int BIN_W         = 10;
	localparam int MAG_W         = 16;
	localparam int MIC_SHIFT     = 2;
	localparam int SUM_W         = MAG_W + MIC_SHIFT;
	localparam int BAND_COUNT    = 5;
	localparam int BAND_W        = 2 * BIN_W;
	localparam int CMD_W         = 3;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = BAND_W;
	// Wide enough to hold the bin limit itself next to any bin index.
	localparam int BIN_LIMIT_W   = (($clog2(SPECTRUM_BINS) + 1) > (BIN_W + 1)) ?
	                               ($clog2(SPECTRUM_BINS) + 1) : (BIN_W + 1);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_ONE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_TWO   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_THREE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_FOUR  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_FIVE  = 3'd7;

	localparam logic [CMD_W-1:0] CMD_NO_SOUND = 3'd0;

	typedef logic [BAND_W-1:0] band_cfg_t;
	typedef band_cfg_t [BAND_COUNT-1:0] band_set_t;

	typedef struct packed {
		logic [BIN_W-1:0] bin_index;
		logic [MAG_W-1:0] mag_front;
		logic [MAG_W-1:0] mag_back;
		logic [MAG_W-1:0] mag_left;
		logic [MAG_W-1:0] mag_right;
		logic             final_bin;
	} in_data_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [BIN_W-1:0] peak_bin;
		logic             peak_found;
		logic             confirmed;
	} out_data_t;

endpackage

[design/spd_band_map.sv]
// Priority band lookup: maps a peak bin to the lowest-numbered band containing it.
module spd_band_map (
	input  spd_pkg::band_set_t              bands,
	input  logic [spd_pkg::BIN_W-1:0]       bin,
	input  logic                            found,
	output logic [spd_pkg::CMD_W-1:0]       command
);
	import spd_pkg::*;

	always_comb begin
		logic [BIN_W-1:0] lo;
		logic [BIN_W-1:0] hi;
		command = CMD_NO_SOUND;
		// Walk from the top band down so the lowest match lands last.
		for (int k = BAND_COUNT - 1; k >= 0; k--) begin
			lo = bands[k][BIN_W-1:0];
			hi = bands[k][BAND_W-1:BIN_W];
			if (found && bin >= lo && bin <= hi) begin
				command = CMD_W'(k + 1);
			end
		end
	end

endmodule

[design/spectral_peak_command_detector.sv]
// Top level of the spectral peak command detector: peak search, band map, output.
// Path: a final-bin word is accepted into the input register, searched in the s1 stage,
// registered into s2, mapped to a band there and registered onto out_valid.
// Throughput: one bin word per cycle; a final word stalls until s2 has room.
// Reset (arst_n low) clears the pipeline valids, the running peak and the previous
// command, and loads the registers: threshold 0, min_bin 0, max_bin 1023, bands 0.
module spectral_peak_command_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  spd_pkg::in_data_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output spd_pkg::out_data_t                out_data,
	input  logic                              cfg_we,
	input  logic [spd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import spd_pkg::*;

	// Configuration registers.
	logic [MAG_W-1:0] threshold_q;
	logic [BIN_W-1:0] min_bin_q;
	logic [BIN_W-1:0] max_bin_q;
	band_set_t        bands_q;

	// Running frame search state.
	logic [MAG_W-1:0] best_average_q;
	logic [BIN_W-1:0] best_bin_q;
	logic             have_peak_q;
	logic [CMD_W-1:0] prev_command_q;

	// Pipeline registers.
	logic             valid_s1;
	in_data_t         data_s1;
	logic             valid_s2;
	logic             found_s2;
	logic [BIN_W-1:0] pbin_s2;
	logic             out_valid_q;
	out_data_t        out_q;

	// Handshake flow.
	logic out_free;
	logic adv_s2;
	logic free_s2;
	logic adv_s1;

	// Search datapath.
	logic [SUM_W-1:0]       mag_sum;
	logic [MAG_W-1:0]       average;
	logic [MAG_W-1:0]       compare_ref;
	logic                   in_window;
	logic                   take_peak;
	logic [MAG_W-1:0]       next_average;
	logic [BIN_W-1:0]       next_bin;
	logic                   next_have;
	logic [CMD_W-1:0]       band_command;

	// ---------------------------------------------------------------
	// Configuration writes: mask each register to its width.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			min_bin_q   <= '0;
			max_bin_q   <= '1;
			bands_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD:  threshold_q <= cfg_data[MAG_W-1:0];
				REG_MIN_BIN:    min_bin_q   <= cfg_data[BIN_W-1:0];
				REG_MAX_BIN:    max_bin_q   <= cfg_data[BIN_W-1:0];
				REG_BAND_ONE:   bands_q[0]  <= cfg_data[BAND_W-1:0];
				REG_BAND_TWO:   bands_q[1]  <= cfg_data[BAND_W-1:0];
				REG_BAND_THREE: bands_q[2]  <= cfg_data[BAND_W-1:0];
				REG_BAND_FOUR:  bands_q[3]  <= cfg_data[BAND_W-1:0];
				REG_BAND_FIVE:  bands_q[4]  <= cfg_data[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Flow control. A non-final word retires in s1 with no result, so it
	// only needs s1 to move; a final word must find room in s2.
	// ---------------------------------------------------------------
	assign out_free = !out_valid_q || out_ready;
	assign adv_s2   = valid_s2 && out_free;
	assign free_s2  = !valid_s2 || adv_s2;
	assign adv_s1   = valid_s1 && (!data_s1.final_bin || free_s2);
	assign in_ready = !valid_s1 || adv_s1;

	// Input register: hold the word until s1 retires it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// ---------------------------------------------------------------
	// s1: four-microphone average and running peak compare. The sum
	// keeps all 18 bits, so the average never wraps.
	// ---------------------------------------------------------------
	assign mag_sum = SUM_W'(data_s1.mag_front) + SUM_W'(data_s1.mag_back)
	               + SUM_W'(data_s1.mag_left) + SUM_W'(data_s1.mag_right);
	assign average = mag_sum[SUM_W-1:MIC_SHIFT];

	assign in_window = (data_s1.bin_index >= min_bin_q) && (data_s1.bin_index <= max_bin_q)
	                && (BIN_LIMIT_W'(data_s1.bin_index) < BIN_LIMIT_W'(SPECTRUM_BINS));

	// Before a peak is held the threshold is the bar; afterwards the held peak.
	assign compare_ref = have_peak_q ? best_average_q : threshold_q;
	// Strictly larger replaces, so ties keep the earlier bin.
	assign take_peak   = in_window && (average > compare_ref);

	assign next_average = take_peak ? average : best_average_q;
	assign next_bin     = take_peak ? data_s1.bin_index : best_bin_q;
	assign next_have    = take_peak || have_peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_average_q <= '0;
			best_bin_q     <= '0;
			have_peak_q    <= 1'b0;
		end else if (adv_s1) begin
			if (data_s1.final_bin) begin
				// Frame done: clear the search for the next frame.
				best_average_q <= '0;
				best_bin_q     <= '0;
				have_peak_q    <= 1'b0;
			end else begin
				best_average_q <= next_average;
				best_bin_q     <= next_bin;
				have_peak_q    <= next_have;
			end
		end
	end

	// s2 holds the frame outcome of a final word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= adv_s1 && data_s1.final_bin;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && data_s1.final_bin) begin
			found_s2 <= next_have;
			pbin_s2  <= next_have ? next_bin : '0;
		end
	end

	// ---------------------------------------------------------------
	// s2: band lookup and confirmation against the previous frame.
	// ---------------------------------------------------------------
	spd_band_map u_band_map (
		.bands   (bands_q),
		.bin     (pbin_s2),
		.found   (found_s2),
		.command (band_command)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_command_q <= CMD_NO_SOUND;
			out_valid_q    <= 1'b0;
		end else begin
			if (adv_s2) begin
				prev_command_q <= band_command;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			out_q.command    <= band_command;
			out_q.peak_bin   <= pbin_s2;
			out_q.peak_found <= found_s2;
			out_q.confirmed  <= (band_command == prev_command_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------------------------------------------------------
	// Checks.
	// ---------------------------------------------------------------
	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && data_s1.final_bin) |=> (!have_peak_q && best_average_q == '0))
		else $error("search state not cleared after final bin");

	a_no_peak_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!have_peak_q |-> (best_average_q == '0 && best_bin_q == '0))
		else $error("stale peak held without a peak flag");

	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.command <= CMD_W'(BAND_COUNT)))
		else $error("command outside band range");

	a_no_peak_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.peak_found)
		|-> (out_q.command == CMD_NO_SOUND && out_q.peak_bin == '0))
		else $error("no-peak result carries a band or bin");

	a_s2_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !data_s1.final_bin && !valid_s2) |=> !valid_s2)
		else $error("non-final word produced a frame result");

endmodule
